@@ rtl/core/iqtr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_pkg
// Shared constants and controller/datapath signal groups for the rotator.
// ----------------------------------------------------------------------------
package iqtr_pkg;

  localparam int MAX_DIM     = 256;
  localparam int DIM_BITS    = $clog2(MAX_DIM);          // coordinate width
  localparam int SIZE_BITS   = 9;                        // size register width
  localparam int PIXEL_BITS  = 24;
  localparam int ADDR_BITS   = 2 * DIM_BITS;             // frame store address
  localparam int TOTAL_BITS  = ADDR_BITS + 1;            // pixel count W*H
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = SIZE_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TURNS  = 2'd2;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // quarter-turn codes
  localparam logic [1:0] TURN_0 = 2'd0;
  localparam logic [1:0] TURN_1 = 2'd1;
  localparam logic [1:0] TURN_2 = 2'd2;
  localparam logic [1:0] TURN_3 = 2'd3;

  typedef struct packed {
    logic load;      // write request pixel into frame store
    logic fetch;     // read next rotated pixel from frame store
    logic out_load;  // move fetched pixel into output register
  } iqtr_cmd_t;

  typedef struct packed {
    logic frame_full;
  } iqtr_status_t;

endpackage

@@ rtl/core/iqtr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_if
// Request and result channels of the rotator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iqtr_req_if
  import iqtr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output op, output pixel_value, input ready);
  modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

interface iqtr_rsp_if
  import iqtr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

@@ rtl/core/image_quarter_turn_rotator_top.sv @@
`timescale 1ns / 1ps
// A load request is written to the frame store at the edge that accepts it.
// A read request's pixel is read from the frame store into a register at its
// accepting edge, then moved into the output register once that is free.
// Loads are taken one per cycle while the controller is idle. A read moves it to the
// fetch state over the registered frame store read port; no request is taken there.
// Reset (rst, synchronous, active high): size 1x1, one quarter turn, empty frame.
// The frame store has no reset; only entries written by the current frame are read.
// ----------------------------------------------------------------------------
// image_quarter_turn_rotator_top
// Frame rotation engine: pixels are loaded in source raster order, stored at
// their rotated address, then read out in destination raster order.
// ----------------------------------------------------------------------------
module image_quarter_turn_rotator_top
  import iqtr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  iqtr_req_if.sink                 req,
  iqtr_rsp_if.source               rsp,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Controller and datapath talk only through these two groups.
  iqtr_cmd_t    cmd;
  iqtr_status_t status;

  // Controller: owns the handshakes. Takes requests while idle; a read that
  // finds a full frame moves to the fetch state and leaves it once the output
  // register is free, so a pending result does not block new requests beyond
  // that single fetch.
  iqtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: config registers, counters, one multiply-add for the rotated
  // write address, the frame store and the output payload register.
  // A config write to a valid register abandons the current frame.
  iqtr_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (req.pixel_value),
    .cmd         (cmd),
    .status      (status),
    .pixel_out   (rsp.pixel_out),
    .last_pixel  (rsp.last_pixel)
  );

endmodule

@@ rtl/core/iqtr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_ctrl
// Request sequencing: loads are written when accepted, reads fetch then present.
// ----------------------------------------------------------------------------
module iqtr_ctrl
  import iqtr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_op,
  output logic         req_ready,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  input  iqtr_status_t status,
  output iqtr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;
  logic   rsp_valid_next;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd.load     = accept && (req_op == OP_LOAD) && !status.frame_full;
    cmd.fetch    = accept && (req_op == OP_READ) && status.frame_full;
    cmd.out_load = (state == ST_FETCH) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.fetch) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ rtl/core/iqtr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_dpath
// Config registers, position counters, rotated address and frame store.
// ----------------------------------------------------------------------------
module iqtr_dpath
  import iqtr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [PIXEL_BITS-1:0]    pixel_value,
  input  iqtr_cmd_t                cmd,
  output iqtr_status_t             status,
  output logic [PIXEL_BITS-1:0]    pixel_out,
  output logic                     last_pixel
);

  logic [SIZE_BITS-1:0] image_width, image_height;
  logic [1:0]           quarter_turns;
  logic [DIM_BITS-1:0]  load_col, load_row;
  logic                 frame_full;
  logic [ADDR_BITS-1:0] read_pos;

  logic [PIXEL_BITS-1:0] frame_store [MAX_DIM*MAX_DIM];
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  rd_last;

  logic                  cfg_hit;
  logic [SIZE_BITS-1:0]  w, h;
  logic [TOTAL_BITS-1:0] total;
  logic [DIM_BITS-1:0]   x_rev, y_rev, term_a, term_b;
  logic [SIZE_BITS-1:0]  term_m;
  logic [TOTAL_BITS:0]   addr_full;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic                  last;
  logic                  col_wrap, row_wrap;
  logic [SIZE_BITS-1:0]  col_inc, row_inc;

  function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [SIZE_BITS-1:0] v);
    if (v == '0) return SIZE_BITS'(1);
    if (v > SIZE_BITS'(MAX_DIM)) return SIZE_BITS'(MAX_DIM);
    return v;
  endfunction

  assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                              cfg_index == REG_TURNS);
  assign w       = clamp_dim(image_width);
  assign h       = clamp_dim(image_height);
  assign total   = TOTAL_BITS'(w * h);
  assign last    = ({1'b0, read_pos} + TOTAL_BITS'(1)) >= total;

  // mirrored coordinates; x < w and y < h, so these fit in DIM_BITS
  assign x_rev = DIM_BITS'(w - SIZE_BITS'(1) - {1'b0, load_col});
  assign y_rev = DIM_BITS'(h - SIZE_BITS'(1) - {1'b0, load_row});

  // rotated address = term_a * term_m + term_b
  always_comb begin
    case (quarter_turns)
      TURN_0: begin term_a = load_row; term_m = w; term_b = load_col; end
      TURN_1: begin term_a = load_col; term_m = h; term_b = y_rev;    end
      TURN_2: begin term_a = y_rev;    term_m = w; term_b = x_rev;    end
      default: begin term_a = x_rev;   term_m = h; term_b = load_row; end
    endcase
  end

  assign addr_full = (TOTAL_BITS+1)'(term_a * term_m) + (TOTAL_BITS+1)'(term_b);
  assign wr_addr   = addr_full[ADDR_BITS-1:0];

  assign col_inc  = {1'b0, load_col} + SIZE_BITS'(1);
  assign row_inc  = {1'b0, load_row} + SIZE_BITS'(1);
  assign col_wrap = col_inc >= w;
  assign row_wrap = row_inc >= h;

  assign status.frame_full = frame_full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= SIZE_BITS'(1);
      image_height  <= SIZE_BITS'(1);
      quarter_turns <= TURN_1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data;
        REG_HEIGHT: image_height  <= cfg_data;
        REG_TURNS:  quarter_turns <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_col   <= '0;
      load_row   <= '0;
      frame_full <= 1'b0;
      read_pos   <= '0;
    end else if (cmd.load) begin
      if (col_wrap) begin
        load_col <= '0;
        if (row_wrap) begin
          load_row   <= '0;
          frame_full <= 1'b1;
        end else begin
          load_row <= row_inc[DIM_BITS-1:0];
        end
      end else begin
        load_col <= col_inc[DIM_BITS-1:0];
      end
    end else if (cmd.fetch) begin
      if (last) begin
        load_col   <= '0;
        load_row   <= '0;
        frame_full <= 1'b0;
        read_pos   <= '0;
      end else begin
        read_pos <= read_pos + ADDR_BITS'(1);
      end
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) frame_store[wr_addr] <= pixel_value;
    if (cmd.fetch) begin
      rd_data <= frame_store[read_pos];
      rd_last <= last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out  <= rd_data;
      last_pixel <= rd_last;
    end
  end

endmodule
